### hdl/uart_buffered_channel_defines.svh
// ----------------------------------------------------------------------------
// UART buffered channel assertion macros
// Shared assertion forms for the buffered byte channel.
// ----------------------------------------------------------------------------
`ifndef UART_BUFFERED_CHANNEL_DEFINES_SVH
`define UART_BUFFERED_CHANNEL_DEFINES_SVH

// same-cycle implication, disabled in reset
`define UBC_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("%m: same-cycle check failed");

// next-cycle implication, disabled in reset
`define UBC_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("%m: next-cycle check failed");

`endif

### hdl/ubc_pkg.sv
// ----------------------------------------------------------------------------
// UART buffered channel package
// Constants, types and ring helpers shared by the channel modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ubc_pkg;

    localparam int RING_DEPTH   = 512;
    localparam int MAX_TX_BURST = 16;
    localparam int RESULT_CAP   = 16;
    localparam int BURST_CAP    = (MAX_TX_BURST < RESULT_CAP) ? MAX_TX_BURST : RESULT_CAP;
    localparam int PTR_W        = $clog2(RING_DEPTH);
    localparam int CNT_W        = PTR_W + 1;
    localparam int ROOM_W       = 5;
    localparam int CMP_W        = (CNT_W > ROOM_W) ? CNT_W : ROOM_W;
    localparam int BURST_W      = $clog2(BURST_CAP + 1);

    typedef logic [PTR_W-1:0]   ptr_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [CMP_W-1:0]   cmp_t;
    typedef logic [BURST_W-1:0] burst_t;
    typedef logic [7:0]         byte_t;

    typedef enum logic [1:0] {
        CMD_WRITE    = 2'd0,
        CMD_READ     = 2'd1,
        CMD_TX_READY = 2'd2,
        CMD_RX_BYTE  = 2'd3
    } ubc_cmd_t;

    typedef enum logic [1:0] {
        RXS_STORED  = 2'd0,
        RXS_DROPPED = 2'd1,
        RXS_FULL    = 2'd2,
        RXS_NONE    = 2'd3
    } ubc_rx_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SIZE,
        ST_FETCH,
        ST_EMIT
    } ubc_state_t;

    typedef struct packed {
        ubc_cmd_t          command;
        byte_t             write_byte;
        byte_t             rx_byte;
        logic              rx_parity_error;
        logic              rx_framing_error;
        logic [ROOM_W-1:0] tx_room;
    } ubc_item_t;

    typedef struct packed {
        logic           read_valid;
        byte_t          read_byte;
        logic           write_accepted;
        ubc_rx_status_t rx_status;
        logic           tx_valid;
        byte_t          tx_byte;
        logic           tx_irq_enable;
        logic           readable;
        logic           writeable;
        logic           wake;
        logic           last;
    } ubc_result_t;

    typedef struct packed {
        logic  we;
        ptr_t  waddr;
        byte_t wdata;
        logic  re;
        ptr_t  raddr;
    } ubc_mem_req_t;

    function automatic ptr_t ptr_next(input ptr_t p);
        return (p == ptr_t'(RING_DEPTH - 1)) ? '0 : p + ptr_t'(1);
    endfunction

    function automatic cnt_t ring_count(input ptr_t head, input ptr_t tail);
        cnt_t diff;
        if (tail >= head)
            diff = cnt_t'(tail) - cnt_t'(head);
        else
            diff = cnt_t'(tail) + cnt_t'(RING_DEPTH) - cnt_t'(head);
        return diff;
    endfunction

endpackage

`default_nettype wire

### hdl/ubc_channels.sv
// ----------------------------------------------------------------------------
// UART buffered channel stream interfaces
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface ubc_item_if import ubc_pkg::*; ();
    logic      valid;
    logic      ready;
    ubc_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ubc_result_if import ubc_pkg::*; ();
    logic        valid;
    logic        ready;
    ubc_result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### hdl/ubc_ram.sv
// ----------------------------------------------------------------------------
// UART buffered channel ring RAM
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ubc_ram #(
    parameter int DEPTH = 512,
    parameter int WIDTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### hdl/ubc_ctrl.sv
// ----------------------------------------------------------------------------
// UART buffered channel sequencer
// Ring pointers, command execution and per-byte drain of the transmit ring.
// ----------------------------------------------------------------------------
`default_nettype none

module ubc_ctrl import ubc_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    ubc_item_if.sink         item,
    ubc_result_if.source     result,
    output ubc_mem_req_t     rx_req,
    output ubc_mem_req_t     tx_req,
    input  wire byte_t       rx_q,
    input  wire byte_t       tx_q
);

    ubc_state_t     state_reg, state_next;
    ubc_item_t      item_reg, item_next;
    ptr_t           rx_head_reg, rx_head_next;
    ptr_t           rx_tail_reg, rx_tail_next;
    ptr_t           tx_head_reg, tx_head_next;
    ptr_t           tx_tail_reg, tx_tail_next;
    logic           irq_reg, irq_next;
    logic           read_valid_reg, read_valid_next;
    logic           write_acc_reg, write_acc_next;
    logic           wake_reg, wake_next;
    logic           drain_reg, drain_next;
    ubc_rx_status_t rx_status_reg, rx_status_next;
    burst_t         rem_reg, rem_next;

    logic rx_empty;
    logic rx_full;
    logic tx_full;
    logic item_fire;
    logic result_fire;
    cnt_t tx_count;
    cmp_t limit;
    cmp_t count_ext;
    cmp_t drain_n;

    assign rx_empty    = (rx_head_reg == rx_tail_reg);
    assign rx_full     = (ptr_next(rx_tail_reg) == rx_head_reg);
    assign tx_full     = (ptr_next(tx_tail_reg) == tx_head_reg);
    assign item_fire   = item.valid && item.ready;
    assign result_fire = result.valid && result.ready;

    assign tx_count  = ring_count(tx_head_reg, tx_tail_reg);
    assign count_ext = cmp_t'(tx_count);
    assign limit     = (cmp_t'(item_reg.tx_room) > cmp_t'(BURST_CAP))
                       ? cmp_t'(BURST_CAP) : cmp_t'(item_reg.tx_room);
    assign drain_n   = (count_ext < limit) ? count_ext : limit;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_fire)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (item_reg.command == CMD_WRITE || item_reg.command == CMD_TX_READY)
                    state_next = ST_SIZE;
                else
                    state_next = ST_EMIT;
            end
            ST_SIZE:
            begin
                state_next = (drain_n != '0) ? ST_FETCH : ST_EMIT;
            end
            ST_FETCH:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (result_fire)
                    state_next = (rem_reg > burst_t'(1)) ? ST_FETCH : ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        item_next       = item_reg;
        rx_head_next    = rx_head_reg;
        rx_tail_next    = rx_tail_reg;
        tx_head_next    = tx_head_reg;
        tx_tail_next    = tx_tail_reg;
        irq_next        = irq_reg;
        read_valid_next = read_valid_reg;
        write_acc_next  = write_acc_reg;
        wake_next       = wake_reg;
        drain_next      = drain_reg;
        rx_status_next  = rx_status_reg;
        rem_next        = rem_reg;
        rx_req          = '0;
        tx_req          = '0;
        item.ready      = 1'b0;
        result.valid    = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                item.ready = 1'b1;
                if (item_fire)
                begin
                    item_next       = item.data;
                    read_valid_next = 1'b0;
                    write_acc_next  = 1'b0;
                    wake_next       = 1'b0;
                    drain_next      = 1'b0;
                    rx_status_next  = RXS_NONE;
                    rem_next        = '0;
                end
            end
            ST_EXEC:
            begin
                unique case (item_reg.command)
                    CMD_READ:
                    begin
                        if (!rx_empty)
                        begin
                            rx_req.re       = 1'b1;
                            rx_req.raddr    = rx_head_reg;
                            rx_head_next    = ptr_next(rx_head_reg);
                            read_valid_next = 1'b1;
                        end
                    end
                    CMD_RX_BYTE:
                    begin
                        if (rx_full)
                            rx_status_next = RXS_FULL;
                        else if (item_reg.rx_parity_error || item_reg.rx_framing_error)
                            rx_status_next = RXS_DROPPED;
                        else
                        begin
                            rx_req.we      = 1'b1;
                            rx_req.waddr   = rx_tail_reg;
                            rx_req.wdata   = item_reg.rx_byte;
                            rx_tail_next   = ptr_next(rx_tail_reg);
                            rx_status_next = RXS_STORED;
                            wake_next      = 1'b1;
                        end
                    end
                    CMD_WRITE:
                    begin
                        if (!tx_full)
                        begin
                            tx_req.we      = 1'b1;
                            tx_req.waddr   = tx_tail_reg;
                            tx_req.wdata   = item_reg.write_byte;
                            tx_tail_next   = ptr_next(tx_tail_reg);
                            write_acc_next = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_SIZE:
            begin
                rem_next   = burst_t'(drain_n);
                drain_next = (drain_n != '0);
                wake_next  = (drain_n != '0);
                irq_next   = (drain_n != count_ext);
            end
            ST_FETCH:
            begin
                tx_req.re    = 1'b1;
                tx_req.raddr = tx_head_reg;
                tx_head_next = ptr_next(tx_head_reg);
            end
            ST_EMIT:
            begin
                result.valid = 1'b1;
                if (result_fire && rem_reg > burst_t'(1))
                    rem_next = rem_reg - burst_t'(1);
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        result.data.read_valid     = read_valid_reg;
        result.data.read_byte      = read_valid_reg ? rx_q : '0;
        result.data.write_accepted = write_acc_reg;
        result.data.rx_status      = rx_status_reg;
        result.data.tx_valid       = drain_reg;
        result.data.tx_byte        = drain_reg ? tx_q : '0;
        result.data.tx_irq_enable  = irq_reg;
        result.data.readable       = !rx_empty;
        result.data.writeable      = !tx_full;
        result.data.wake           = wake_reg;
        result.data.last           = (rem_reg <= burst_t'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            rx_head_reg    <= '0;
            rx_tail_reg    <= '0;
            tx_head_reg    <= '0;
            tx_tail_reg    <= '0;
            irq_reg        <= 1'b0;
            read_valid_reg <= 1'b0;
            write_acc_reg  <= 1'b0;
            wake_reg       <= 1'b0;
            drain_reg      <= 1'b0;
            rx_status_reg  <= RXS_NONE;
            rem_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            rx_head_reg    <= rx_head_next;
            rx_tail_reg    <= rx_tail_next;
            tx_head_reg    <= tx_head_next;
            tx_tail_reg    <= tx_tail_next;
            irq_reg        <= irq_next;
            read_valid_reg <= read_valid_next;
            write_acc_reg  <= write_acc_next;
            wake_reg       <= wake_next;
            drain_reg      <= drain_next;
            rx_status_reg  <= rx_status_next;
            rem_reg        <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

endmodule

`default_nettype wire

### hdl/uart_buffered_channel.sv
// ----------------------------------------------------------------------------
// UART buffered channel
// Receive and transmit byte rings between a host and a UART, with a
// sequencer that drains the transmit ring one byte per result.
// ----------------------------------------------------------------------------
//  channel  dir  payload       transfer
//  item     in   ubc_item_t    valid && ready, one command
//  result   out  ubc_result_t  valid && ready, one per drained byte (min one)
//
//  Read and receive commands pass from idle through execute to emit; write and
//  transmitter-ready commands also pass a sizing state, then fetch and emit once
//  per drained byte (up to 16 bytes), as the transmit ring has a registered
//  single read port.
//  No item is taken until the last result of the current one has transferred.
//  A stalled result holds until ready. Reset clears the ring pointers and the
//  sequencer state and flags, not the ring contents; no clearing pass is run.
// ----------------------------------------------------------------------------
`default_nettype none

`include "uart_buffered_channel_defines.svh"

module uart_buffered_channel import ubc_pkg::*; (
    input  wire logic    clk,
    input  wire logic    rst_n,
    ubc_item_if.sink     item,
    ubc_result_if.source result
);

    ubc_mem_req_t rx_req;
    ubc_mem_req_t tx_req;
    byte_t        rx_q;
    byte_t        tx_q;

    ubc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .result (result),
        .rx_req (rx_req),
        .tx_req (tx_req),
        .rx_q   (rx_q),
        .tx_q   (tx_q)
    );

    ubc_ram #(
        .DEPTH (RING_DEPTH),
        .WIDTH (8)
    ) u_rx_ram (
        .clk   (clk),
        .we    (rx_req.we),
        .waddr (rx_req.waddr),
        .wdata (rx_req.wdata),
        .re    (rx_req.re),
        .raddr (rx_req.raddr),
        .rdata (rx_q)
    );

    ubc_ram #(
        .DEPTH (RING_DEPTH),
        .WIDTH (8)
    ) u_tx_ram (
        .clk   (clk),
        .we    (tx_req.we),
        .waddr (tx_req.waddr),
        .wdata (tx_req.wdata),
        .re    (tx_req.re),
        .raddr (tx_req.raddr),
        .rdata (tx_q)
    );

    `UBC_ASSERT_NOW(a_one_side, result.valid, !item.ready)
    `UBC_ASSERT_NOW(a_idle_single, result.valid && !result.data.tx_valid, result.data.last)
    `UBC_ASSERT_NOW(a_read_zero, result.valid && !result.data.read_valid, result.data.read_byte == 8'd0)
    `UBC_ASSERT_NEXT(a_last_frees, result.valid && result.ready && result.data.last, item.ready)

endmodule

`default_nettype wire

### tb/uart_buffered_channel_checker.sv
// ----------------------------------------------------------------------------
// UART buffered channel checker
// Watches the command and result channels. For every accepted command it
// keeps its own copy of both rings and the interrupt enable and works out
// the results due. Each accepted result is compared field by field with the
// oldest result still due.
// ----------------------------------------------------------------------------
module uart_buffered_channel_checker import ubc_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    ubc_item_if       item_bus,
    ubc_result_if     result_bus,
    output int        failures,
    output int        pending
);

    byte_t       rx_ring [RING_DEPTH];
    byte_t       tx_ring [RING_DEPTH];
    ptr_t        rx_rd;
    ptr_t        rx_wr;
    ptr_t        tx_rd;
    ptr_t        tx_wr;
    logic        irq_armed;
    ubc_result_t due_results [$];

    function automatic ptr_t step_ptr(input ptr_t p);
        return ptr_t'((int'(p) + 1) % RING_DEPTH);
    endfunction

    function automatic bit field_ok(input string name, input int unsigned want,
                                    input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic apply_command(input ubc_item_t it);
        ubc_result_t base;
        ubc_result_t r;
        byte_t       moved [$];
        int          burst;
        base = '0;
        base.rx_status = RXS_NONE;
        case (it.command)
            CMD_READ:
            begin
                if (rx_rd != rx_wr)
                begin
                    base.read_valid = 1'b1;
                    base.read_byte  = rx_ring[rx_rd];
                    rx_rd = step_ptr(rx_rd);
                end
            end
            CMD_RX_BYTE:
            begin
                if (step_ptr(rx_wr) == rx_rd)
                    base.rx_status = RXS_FULL;
                else if (it.rx_parity_error || it.rx_framing_error)
                    base.rx_status = RXS_DROPPED;
                else
                begin
                    rx_ring[rx_wr] = it.rx_byte;
                    rx_wr = step_ptr(rx_wr);
                    base.rx_status = RXS_STORED;
                    base.wake      = 1'b1;
                end
            end
            default:
            begin
                if (it.command == CMD_WRITE && step_ptr(tx_wr) != tx_rd)
                begin
                    tx_ring[tx_wr] = it.write_byte;
                    tx_wr = step_ptr(tx_wr);
                    base.write_accepted = 1'b1;
                end
                burst = int'(it.tx_room);
                if (burst > MAX_TX_BURST)
                    burst = MAX_TX_BURST;
                if (burst > RESULT_CAP)
                    burst = RESULT_CAP;
                while (tx_rd != tx_wr && moved.size() < burst)
                begin
                    moved.push_back(tx_ring[tx_rd]);
                    tx_rd = step_ptr(tx_rd);
                end
                irq_armed = (tx_rd != tx_wr);
                if (moved.size() > 0)
                    base.wake = 1'b1;
            end
        endcase
        base.tx_irq_enable = irq_armed;
        base.readable      = (rx_rd != rx_wr);
        base.writeable     = (step_ptr(tx_wr) != tx_rd);
        if (moved.size() == 0)
        begin
            base.last = 1'b1;
            due_results.push_back(base);
        end
        else
        begin
            foreach (moved[k])
            begin
                r = base;
                r.tx_valid = 1'b1;
                r.tx_byte  = moved[k];
                r.last     = (k == moved.size() - 1);
                due_results.push_back(r);
            end
        end
    endtask

    task automatic check_result(input ubc_result_t got);
        ubc_result_t want;
        bit          ok;
        if (due_results.size() == 0)
        begin
            $error("result transfer with nothing due: 0x%0h", got);
            failures++;
            return;
        end
        want = due_results.pop_front();
        ok = 1'b1;
        ok &= field_ok("read_valid", want.read_valid, got.read_valid);
        ok &= field_ok("read_byte", want.read_byte, got.read_byte);
        ok &= field_ok("write_accepted", want.write_accepted, got.write_accepted);
        ok &= field_ok("rx_status", want.rx_status, got.rx_status);
        ok &= field_ok("tx_valid", want.tx_valid, got.tx_valid);
        ok &= field_ok("tx_byte", want.tx_byte, got.tx_byte);
        ok &= field_ok("tx_irq_enable", want.tx_irq_enable, got.tx_irq_enable);
        ok &= field_ok("readable", want.readable, got.readable);
        ok &= field_ok("writeable", want.writeable, got.writeable);
        ok &= field_ok("wake", want.wake, got.wake);
        ok &= field_ok("last", want.last, got.last);
        if (!ok)
            failures++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_rd     = '0;
            rx_wr     = '0;
            tx_rd     = '0;
            tx_wr     = '0;
            irq_armed = 1'b0;
            due_results.delete();
            pending  <= 0;
        end
        else
        begin
            if (result_bus.valid && result_bus.ready)
                check_result(result_bus.data);
            if (item_bus.valid && item_bus.ready)
                apply_command(item_bus.data);
            pending <= due_results.size();
        end
    end

endmodule

### tb/uart_buffered_channel_test.sv
// ----------------------------------------------------------------------------
// UART buffered channel testbench
// Drives host writes, host reads, transmitter-ready events and received
// bytes into the channel: a directed opening with errored bytes and
// oversized transmit room, then random commands with random idling on both
// channels and one long result hold-off. A checker beside the block scores
// results.
// ----------------------------------------------------------------------------
module uart_buffered_channel_test;
    import ubc_pkg::*;

    localparam int CYCLE_LIMIT = 3 * 250 * (16 * 70 + 100) + 400;
    localparam int HOLD_CYCLES = 400;
    localparam int RANDOM_ITEMS = 180;

    logic clk = 1'b0;
    logic rst_n;
    bit   steady_source;
    bit   steady_sink;
    bit   hold_off;
    int   failure_count;
    int   pending_count;

    ubc_item_if   item_bus ();
    ubc_result_if result_bus ();

    uart_buffered_channel u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_bus),
        .result (result_bus)
    );

    uart_buffered_channel_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_bus   (item_bus),
        .result_bus (result_bus),
        .failures   (failure_count),
        .pending    (pending_count)
    );

    always #6 clk = ~clk;

    function automatic int idle_span();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            return 0;
        if (pick < 85)
            return $urandom_range(1, 3);
        if (pick < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic ubc_item_t compose(input ubc_cmd_t cmd, input byte_t wbyte,
                                          input byte_t rbyte, input logic perr,
                                          input logic ferr, input int room);
        ubc_item_t it;
        it.command          = cmd;
        it.write_byte       = wbyte;
        it.rx_byte          = rbyte;
        it.rx_parity_error  = perr;
        it.rx_framing_error = ferr;
        it.tx_room          = ROOM_W'(room);
        return it;
    endfunction

    function automatic ubc_item_t random_item();
        ubc_item_t it;
        int        pick;
        pick = $urandom_range(0, 99);
        it.command = (pick < 35) ? CMD_WRITE :
                     (pick < 60) ? CMD_READ :
                     (pick < 75) ? CMD_TX_READY : CMD_RX_BYTE;
        it.write_byte       = byte_t'($urandom);
        it.rx_byte          = byte_t'($urandom);
        it.rx_parity_error  = ($urandom_range(0, 7) == 0);
        it.rx_framing_error = ($urandom_range(0, 7) == 0);
        pick = $urandom_range(0, 9);
        if (pick < 6)
            it.tx_room = ROOM_W'($urandom_range(0, 4));
        else if (pick < 9)
            it.tx_room = ROOM_W'($urandom_range(5, 16));
        else
            it.tx_room = ROOM_W'($urandom_range(17, 31));
        return it;
    endfunction

    task automatic offer(input ubc_item_t it);
        int gap;
        gap = steady_source ? 0 : idle_span();
        if (gap > 0)
        begin
            item_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_bus.valid <= 1'b1;
        item_bus.data  <= it;
        do
            @(posedge clk);
        while (!item_bus.ready);
    endtask

    initial
    begin : receiver
        int span;
        bit level;
        result_bus.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_off)
            begin
                level    = 1'b0;
                span     = HOLD_CYCLES;
                hold_off = 1'b0;
            end
            else if (steady_sink)
            begin
                level = 1'b1;
                span  = 1;
            end
            else
            begin
                level = ($urandom_range(0, 2) != 0);
                span  = level ? $urandom_range(1, 6) : idle_span() + 1;
            end
            repeat (span)
            begin
                @(posedge clk);
                result_bus.ready <= level;
            end
        end
    end

    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin : stimulus
        item_bus.valid <= 1'b0;
        item_bus.data  <= '0;
        rst_n          <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        offer(compose(CMD_READ, 8'h00, 8'h00, 1'b0, 1'b0, 0));
        offer(compose(CMD_TX_READY, 8'hFF, 8'hFF, 1'b1, 1'b1, 31));
        offer(compose(CMD_WRITE, 8'h00, 8'hFF, 1'b0, 1'b1, 0));
        offer(compose(CMD_WRITE, 8'hFF, 8'h00, 1'b1, 1'b0, 31));
        offer(compose(CMD_WRITE, 8'hA5, 8'h5A, 1'b0, 1'b0, 0));
        offer(compose(CMD_WRITE, 8'h5A, 8'hA5, 1'b1, 1'b1, 0));
        offer(compose(CMD_WRITE, 8'h3C, 8'hC3, 1'b0, 1'b0, 0));
        offer(compose(CMD_TX_READY, 8'h81, 8'h18, 1'b0, 1'b0, 1));
        offer(compose(CMD_TX_READY, 8'h18, 8'h81, 1'b0, 1'b0, 16));
        offer(compose(CMD_RX_BYTE, 8'h00, 8'hFF, 1'b0, 1'b0, 0));
        offer(compose(CMD_RX_BYTE, 8'hFF, 8'h00, 1'b1, 1'b0, 31));
        offer(compose(CMD_RX_BYTE, 8'h0F, 8'h55, 1'b0, 1'b1, 16));
        offer(compose(CMD_RX_BYTE, 8'hF0, 8'hAA, 1'b1, 1'b1, 17));
        offer(compose(CMD_RX_BYTE, 8'h77, 8'h00, 1'b0, 1'b0, 31));
        offer(compose(CMD_READ, 8'hFF, 8'hFF, 1'b1, 1'b1, 31));
        offer(compose(CMD_READ, 8'h00, 8'h00, 1'b0, 1'b0, 0));
        offer(compose(CMD_READ, 8'h33, 8'hCC, 1'b0, 1'b1, 8));

        offer(compose(CMD_RX_BYTE, 8'h12, 8'h34, 1'b1, 1'b0, 0));
        offer(compose(CMD_RX_BYTE, 8'h56, 8'h78, 1'b0, 1'b0, 0));
        offer(compose(CMD_RX_BYTE, 8'h9A, 8'hBC, 1'b0, 1'b1, 0));
        offer(compose(CMD_WRITE, 8'hDE, 8'hAD, 1'b0, 1'b0, 0));
        offer(compose(CMD_WRITE, 8'hBE, 8'hEF, 1'b0, 1'b0, 5));
        repeat (8)
            offer(compose(CMD_TX_READY, byte_t'($urandom), byte_t'($urandom),
                          1'b0, 1'b0, $urandom_range(16, 31)));

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 35 == 0)
            begin
                steady_source = ($urandom_range(0, 2) == 0);
                steady_sink   = ($urandom_range(0, 2) == 0);
            end
            if (i == 90)
            begin
                steady_sink = 1'b0;
                hold_off    = 1'b1;
            end
            offer(random_item());
        end
        item_bus.valid <= 1'b0;
        steady_sink = 1'b0;

        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (failure_count == 0 && pending_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### sim.f
+incdir+hdl
hdl/ubc_pkg.sv
hdl/ubc_channels.sv
hdl/ubc_ram.sv
hdl/ubc_ctrl.sv
hdl/uart_buffered_channel.sv
tb/uart_buffered_channel_checker.sv
tb/uart_buffered_channel_test.sv
